// ----- sv/interval_timer_three_counters_core_macros.svh -----
// assertion macros shared by the timer rtl
`ifndef INTERVAL_TIMER_THREE_COUNTERS_CORE_MACROS_SVH
`define INTERVAL_TIMER_THREE_COUNTERS_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define ITC_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define ITC_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define ITC_ASSERT(lbl, ck, rs, prop, msg)
`define ITC_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

// ----- sv/itc_pkg.sv -----
package itc_pkg;

  localparam int NUM_CTR_DEFAULT = 3;
  localparam int CTR_MAX = 3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_GATE  = 2'd3
  } op_t;

  localparam logic [1:0] PORT_CTRL = 2'd3;
  localparam logic [1:0] SEL_READBACK = 2'd3;

  // access codes, also used as byte phase of the read/write sequencers
  localparam logic [1:0] RW_LATCH = 2'd0;
  localparam logic [1:0] RW_LSB   = 2'd1;
  localparam logic [1:0] RW_MSB   = 2'd2;
  localparam logic [1:0] RW_BOTH  = 2'd3;

  localparam logic [2:0] MODE_0 = 3'd0;
  localparam logic [2:0] MODE_1 = 3'd1;
  localparam logic [2:0] MODE_2 = 3'd2;
  localparam logic [2:0] MODE_3 = 3'd3;
  localparam logic [2:0] MODE_LAST = 3'd5;
  localparam logic [2:0] MODE_FOLD = 3'd4;

  localparam int FL_BCD      = 0;
  localparam int FL_LATCH    = 1;
  localparam int FL_NEW      = 2;
  localparam int FL_STAT     = 3;
  localparam int FL_COUNTING = 4;
  localparam int FL_UPDATE   = 5;

  localparam logic [16:0] BCD_MAX    = 17'd9999;
  localparam logic [16:0] FULL_COUNT = 17'h10000;

  typedef struct packed {
    logic [16:0] reload;
    logic [16:0] period;
    logic [16:0] phase;
    logic        past;
    logic [15:0] rhold;
    logic [15:0] whold;
    logic [2:0]  mode;
    logic [1:0]  rphase;
    logic [1:0]  wphase;
    logic [5:0]  flags;
  } ctr_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic       status_locked;
    logic       gate_two;
  } glb_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] port;
    logic [7:0] data;
    logic       gate_level;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq0_raise;
    logic       irq0_drop;
    logic       speaker_out;
  } res_t;

  function automatic ctr_t ctr_init(int i);
    ctr_t k;
    k = '0;
    k.flags[FL_LATCH] = 1'b1;
    k.wphase = RW_BOTH;
    case (i)
      0: begin
        k.reload = FULL_COUNT; k.rhold = 16'd0; k.mode = MODE_3; k.rphase = RW_BOTH;
      end
      1: begin
        k.reload = 17'd18; k.rhold = 16'd0; k.mode = MODE_2; k.rphase = RW_LSB;
      end
      default: begin
        k.reload = 17'd1320; k.rhold = 16'd1320; k.mode = MODE_3; k.rphase = RW_BOTH;
      end
    endcase
    k.period = k.reload;
    return k;
  endfunction

  function automatic logic is_div_mode(logic [2:0] m);
    return (m == MODE_2) || (m == MODE_3);
  endfunction

  function automatic logic out_level(ctr_t k);
    logic lv;
    case (k.mode)
      MODE_0:  lv = k.flags[FL_NEW] ? 1'b0 : k.past;
      MODE_2:  lv = k.flags[FL_NEW] ? 1'b1 : (k.phase != '0);
      MODE_3:  lv = k.flags[FL_NEW] ? 1'b1 : ({k.phase, 1'b0} < {1'b0, k.period});
      default: lv = 1'b1;
    endcase
    return lv;
  endfunction

  // phase fed to the divider; square wave counts twice per period
  function automatic logic [16:0] div_phase(ctr_t k);
    logic [17:0] t;
    t = {k.phase, 1'b0};
    if ({1'b0, k.period} < t) t = t - {1'b0, k.period};
    return (k.mode == MODE_3) ? t[16:0] : k.phase;
  endfunction

  // q is phase * reload / period for the rate and square modes
  function automatic ctr_t latch_count(ctr_t k, logic gated_off, logic [16:0] q);
    ctr_t r;
    logic [16:0] dif;
    r = k;
    r.flags[FL_LATCH] = 1'b0;
    dif = k.reload - k.phase;
    if (!(gated_off && k.mode != MODE_1)) begin
      case (k.mode)
        MODE_2: r.rhold = 16'(k.reload - q);
        MODE_3: r.rhold = 16'(k.reload - q) & 16'hfffe;
        MODE_1: begin
          if (k.flags[FL_COUNTING]) r.rhold = k.past ? 16'hffff : dif[15:0];
        end
        default: r.rhold = k.past ? (16'hffff - k.phase[15:0]) : dif[15:0];
      endcase
    end
    return r;
  endfunction

endpackage

// ----- sv/interval_timer_three_counters_core.sv -----
// three-counter interval timer core, 8254 style, counting input ticks
// input channel: in_valid/in_stall with opcode, port, data, gate_level; one beat
//   is a tick, a port write, a port read or a new gate 2 level
// output channel: out_valid/out_stall, one result beat per input beat, in order,
//   carrying read_data, irq0_raise, irq0_drop and speaker_out
// path: each beat passes through the item register, then the result register
// throughput: one beat per cycle while the output is not stalled, except that a count
//   latch in mode 2 or 3 runs phase * reload / period through a shared multiply and
//   17-step divider, one latched counter at a time, up to three in one read-back command
// while the result register is full and out_stall is high the block still takes
//   one more beat into its item register, then raises in_stall
// reset (rst, synchronous) loads the power-on counts 65536, 18 and 1320, modes
//   3, 2, 3, clears status lock and gate 2 and empties both registers
`include "interval_timer_three_counters_core_macros.svh"

module interval_timer_three_counters_core #(
  parameter int NUM_COUNTERS = itc_pkg::NUM_CTR_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [1:0] port,
  input  logic [7:0] data,
  input  logic       gate_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       irq0_raise,
  output logic       irq0_drop,
  output logic       speaker_out
);
  import itc_pkg::*;

  item_t                    item_q;
  logic                     iv;
  ctr_t [CTR_MAX-1:0]       ctr, ctr_next;
  glb_t                     glb, glb_next;
  res_t                     res_next;
  logic [CTR_MAX-1:0]       need, qdone, pend;
  logic [CTR_MAX-1:0][16:0] qv;
  logic                     div_run, div_start, div_done;
  logic [16:0]              div_q;
  logic [1:0]               cur, pick;
  logic                     exec_fire, in_take;

  itc_step #(.NUM_COUNTERS(NUM_COUNTERS)) u_step (
    .item    (item_q),
    .ctr_in  (ctr),
    .glb_in  (glb),
    .q       (qv),
    .ctr_out (ctr_next),
    .glb_out (glb_next),
    .res     (res_next),
    .need    (need)
  );

  always_comb begin
    pend = need & ~qdone;
    pick = '0;
    for (int c = CTR_MAX - 1; c >= 0; c--)
      if (pend[c]) pick = 2'(c);
  end

  assign div_start = iv && !div_run && (pend != '0);
  assign exec_fire = iv && !div_run && (pend == '0) && (!out_valid || !out_stall);
  assign in_stall  = iv && !exec_fire;
  assign in_take   = in_valid && !in_stall;

  itc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .ph    (div_phase(ctr[pick])),
    .cnt   (ctr[pick].reload),
    .per   (ctr[pick].period),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
      div_run <= 1'b0;
      qdone <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < CTR_MAX; i++) ctr[i] <= ctr_init(i);
      glb <= '0;
    end else begin
      if (in_take) begin
        iv <= 1'b1;
        item_q <= '{op: op_t'(opcode), port: port, data: data, gate_level: gate_level};
        qdone <= '0;
      end else if (exec_fire) begin
        iv <= 1'b0;
      end
      if (div_start) begin
        div_run <= 1'b1;
        cur <= pick;
      end else if (div_done) begin
        div_run <= 1'b0;
        qdone[cur] <= 1'b1;
        qv[cur] <= div_q;
      end
      if (exec_fire) begin
        ctr <= ctr_next;
        glb <= glb_next;
        out_valid <= 1'b1;
        read_data <= res_next.read_data;
        irq0_raise <= res_next.irq0_raise;
        irq0_drop <= res_next.irq0_drop;
        speaker_out <= res_next.speaker_out;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ITC_ASSERT(a_done_while_run, clk, rst, div_done |-> div_run, "divider done with no request")
  `ITC_ASSERT(a_run_holds_item, clk, rst, div_run |-> iv, "divider running with no item held")
  `ITC_ASSERT(a_qdone_subset, clk, rst, iv |-> ((qdone & ~need) == '0), "stray quotient")
  `ITC_ASSERT(a_irq_exclusive, clk, rst, out_valid |-> !(irq0_raise && irq0_drop), "irq0 raise and drop")

endmodule

// ----- sv/itc_div.sv -----
module itc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] ph,
  input  logic [16:0] cnt,
  input  logic [16:0] per,
  output logic        done,
  output logic [16:0] q
);

  typedef enum logic [1:0] {DV_IDLE, DV_MUL, DV_INIT, DV_RUN} div_state_t;

  div_state_t  state;
  logic [16:0] a, b, d, r, lo;
  logic [33:0] prod;
  logic [4:0]  k;
  logic [17:0] t;
  logic        ge;

  always_comb begin
    t  = {r, lo[16]};
    ge = (t >= {1'b0, d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        DV_IDLE: begin
          if (start) begin
            a <= ph;
            b <= cnt;
            d <= per;
            state <= DV_MUL;
          end
        end
        DV_MUL: begin
          prod  <= a * b;
          state <= DV_INIT;
        end
        DV_INIT: begin
          // quotient fits 17 bits, so the top half is already below the divisor
          r     <= prod[33:17];
          lo    <= prod[16:0];
          k     <= 5'd16;
          state <= DV_RUN;
        end
        DV_RUN: begin
          r  <= ge ? 17'(t - {1'b0, d}) : t[16:0];
          q  <= {q[15:0], ge};
          lo <= {lo[15:0], 1'b0};
          if (k == 5'd0) begin
            state <= DV_IDLE;
            done  <= 1'b1;
          end else begin
            k <= k - 5'd1;
          end
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/itc_step.sv -----
module itc_step #(
  parameter int NUM_COUNTERS = itc_pkg::NUM_CTR_DEFAULT
) (
  input  itc_pkg::item_t                          item,
  input  itc_pkg::ctr_t [itc_pkg::CTR_MAX-1:0]    ctr_in,
  input  itc_pkg::glb_t                           glb_in,
  input  logic [itc_pkg::CTR_MAX-1:0][16:0]       q,
  output itc_pkg::ctr_t [itc_pkg::CTR_MAX-1:0]    ctr_out,
  output itc_pkg::glb_t                           glb_out,
  output itc_pkg::res_t                           res,
  output logic [itc_pkg::CTR_MAX-1:0]             need
);
  import itc_pkg::*;

  ctr_t [CTR_MAX-1:0] s;
  ctr_t               tmp;
  glb_t               gs;
  logic [17:0]        p;
  logic [2:0]         m;
  logic               st_hit;
  logic [1:0]         st_c;
  logic [1:0]         rw;
  logic [7:0]         rd;
  logic               raise, drop;
  logic [CTR_MAX-1:0] req;

  // counters whose count latch needs the divider for this item
  always_comb begin
    req = '0;
    case (item.op)
      OP_READ: begin
        for (int c = 0; c < CTR_MAX; c++)
          if (c == int'(item.port) && c < NUM_COUNTERS && !ctr_in[c].flags[FL_STAT] &&
              ctr_in[c].flags[FL_LATCH]) req[c] = 1'b1;
      end
      OP_WRITE: begin
        if (item.port == PORT_CTRL) begin
          if (item.data[7:6] == SEL_READBACK) begin
            if (!item.data[5])
              for (int c = 0; c < CTR_MAX; c++)
                if (c < NUM_COUNTERS && item.data[c+1]) req[c] = 1'b1;
          end else begin
            for (int c = 0; c < CTR_MAX; c++)
              if (c == int'(item.data[7:6]) && c < NUM_COUNTERS &&
                  item.data[5:4] == RW_LATCH) req[c] = 1'b1;
          end
        end
      end
      OP_GATE: begin
        if (NUM_COUNTERS > 2 && item.gate_level != glb_in.gate_two && !item.gate_level &&
            (ctr_in[2].mode == MODE_0 || is_div_mode(ctr_in[2].mode))) req[2] = 1'b1;
      end
      default: req = '0;
    endcase
    for (int c = 0; c < CTR_MAX; c++)
      need[c] = req[c] && is_div_mode(ctr_in[c].mode) && !(c == 2 && !glb_in.gate_two);
  end

  always_comb begin
    s = ctr_in;
    gs = glb_in;
    rd = '0;
    raise = 1'b0;
    drop = 1'b0;
    p = '0;
    m = '0;
    tmp = '0;
    st_hit = 1'b0;
    st_c = '0;
    rw = '0;
    case (item.op)
      OP_TICK: begin
        for (int c = 0; c < CTR_MAX; c++) begin
          if (c < NUM_COUNTERS && !s[c].flags[FL_NEW]) begin
            p = {1'b0, s[c].phase} + 18'd1;
            if (is_div_mode(s[c].mode)) begin
              if (p >= {1'b0, s[c].period}) begin
                s[c].phase = '0;
                // deferred reload of counter 0 takes effect at the wrap
                if (c == 0 && s[c].flags[FL_UPDATE]) begin
                  s[c].period = (s[c].reload != '0) ? s[c].reload : FULL_COUNT;
                  s[c].flags[FL_UPDATE] = 1'b0;
                end
                if (c == 0) raise = 1'b1;
              end else begin
                s[c].phase = p[16:0];
              end
            end else if (s[c].past) begin
              s[c].phase = {1'b0, p[15:0]};
            end else if (p > {1'b0, s[c].period}) begin
              s[c].past = 1'b1;
              s[c].phase = 17'(p - {1'b0, s[c].period});
              if (c == 0) raise = 1'b1;
            end else begin
              s[c].phase = p[16:0];
            end
          end
        end
      end
      OP_WRITE: begin
        if (item.port == PORT_CTRL) begin
          if (item.data[7:6] == SEL_READBACK) begin
            if (!item.data[5])
              for (int c = 0; c < CTR_MAX; c++)
                if (c < NUM_COUNTERS && item.data[c+1])
                  s[c] = latch_count(s[c], c == 2 && !gs.gate_two, q[c]);
            if (!item.data[4] && !gs.status_locked) begin
              if (item.data[1]) begin
                st_hit = 1'b1; st_c = 2'd0;
              end else if (item.data[2]) begin
                st_hit = 1'b1; st_c = 2'd1;
              end else if (item.data[3]) begin
                st_hit = 1'b1; st_c = 2'd2;
              end
              for (int c = 0; c < CTR_MAX; c++) begin
                if (st_hit && c == int'(st_c) && c < NUM_COUNTERS) begin
                  rw = (s[c].rphase == RW_LATCH) ? RW_BOTH : s[c].rphase;
                  gs.status_byte = {out_level(s[c]), s[c].flags[FL_NEW], rw, s[c].mode,
                                    s[c].flags[FL_BCD]};
                  s[c].flags[FL_STAT] = 1'b1;
                  gs.status_locked = 1'b1;
                end
              end
            end
          end else begin
            for (int c = 0; c < CTR_MAX; c++) begin
              if (c == int'(item.data[7:6]) && c < NUM_COUNTERS) begin
                if (item.data[5:4] == RW_LATCH) begin
                  s[c] = latch_count(s[c], c == 2 && !gs.gate_two, q[c]);
                end else begin
                  if (item.data[0]) begin
                    s[c].flags[FL_BCD] = 1'b1;
                    if (s[c].reload >= BCD_MAX) s[c].reload = BCD_MAX;
                  end else begin
                    s[c].flags[FL_BCD] = 1'b0;
                  end
                  if (s[c].flags[FL_STAT]) begin
                    s[c].flags[FL_STAT] = 1'b0;
                    gs.status_locked = 1'b0;
                  end
                  s[c].flags[FL_UPDATE] = 1'b0;
                  s[c].flags[FL_COUNTING] = 1'b0;
                  s[c].wphase = item.data[5:4];
                  s[c].rphase = item.data[5:4];
                  m = item.data[3:1];
                  if (m > MODE_LAST) m = m - MODE_FOLD;
                  tmp = s[c];
                  if (tmp.mode == MODE_0) tmp.mode = m;
                  if (c == 0) begin
                    if (m == MODE_0) drop = 1'b1;
                    else if (!out_level(tmp)) raise = 1'b1;
                  end
                  s[c].flags[FL_NEW] = 1'b1;
                  s[c].mode = m;
                  s[c].phase = '0;
                  s[c].past = 1'b0;
                end
              end
            end
          end
        end else begin
          for (int c = 0; c < CTR_MAX; c++) begin
            if (c == int'(item.port) && c < NUM_COUNTERS) begin
              case (s[c].wphase)
                RW_LATCH: begin
                  s[c].whold = s[c].whold | {item.data, 8'h00};
                  s[c].wphase = RW_BOTH;
                end
                RW_BOTH: begin
                  s[c].whold = {8'h00, item.data};
                  s[c].wphase = RW_LATCH;
                end
                RW_LSB:  s[c].whold = {8'h00, item.data};
                default: s[c].whold = {item.data, 8'h00};
              endcase
              if (s[c].wphase != RW_LATCH) begin
                if (s[c].whold == '0)
                  s[c].reload = s[c].flags[FL_BCD] ? BCD_MAX : FULL_COUNT;
                else
                  s[c].reload = {1'b0, s[c].whold};
                if (!s[c].flags[FL_NEW] && s[c].mode == MODE_2 && c == 0) begin
                  s[c].flags[FL_UPDATE] = 1'b1;
                end else begin
                  s[c].phase = '0;
                  s[c].past = 1'b0;
                  s[c].period = s[c].reload;
                  s[c].flags[FL_NEW] = 1'b0;
                end
              end
            end
          end
        end
      end
      OP_READ: begin
        for (int c = 0; c < CTR_MAX; c++) begin
          if (c == int'(item.port) && c < NUM_COUNTERS) begin
            if (s[c].flags[FL_STAT]) begin
              s[c].flags[FL_STAT] = 1'b0;
              gs.status_locked = 1'b0;
              rd = gs.status_byte;
            end else begin
              if (s[c].flags[FL_LATCH])
                s[c] = latch_count(s[c], c == 2 && !gs.gate_two, q[c]);
              case (s[c].rphase)
                RW_LATCH: begin
                  rd = s[c].rhold[15:8];
                  s[c].rphase = RW_BOTH;
                  s[c].flags[FL_LATCH] = 1'b1;
                end
                RW_BOTH: begin
                  rd = s[c].rhold[7:0];
                  s[c].rphase = RW_LATCH;
                end
                RW_LSB: begin
                  rd = s[c].rhold[7:0];
                  s[c].flags[FL_LATCH] = 1'b1;
                end
                default: begin
                  rd = s[c].rhold[15:8];
                  s[c].flags[FL_LATCH] = 1'b1;
                end
              endcase
            end
          end
        end
      end
      default: begin
        if (item.gate_level != gs.gate_two) begin
          if (NUM_COUNTERS > 2) begin
            case (s[2].mode)
              MODE_0: begin
                if (item.gate_level) begin
                  s[2].phase = '0;
                  s[2].past = 1'b0;
                end else begin
                  s[2] = latch_count(s[2], !gs.gate_two, q[2]);
                  s[2].reload = {1'b0, s[2].rhold};
                end
              end
              MODE_1: begin
                if (item.gate_level) begin
                  s[2].flags[FL_COUNTING] = 1'b1;
                  s[2].phase = '0;
                  s[2].past = 1'b0;
                end
              end
              MODE_2, MODE_3: begin
                if (item.gate_level) begin
                  s[2].phase = '0;
                  s[2].past = 1'b0;
                end else begin
                  s[2] = latch_count(s[2], !gs.gate_two, q[2]);
                end
              end
              default: s[2] = s[2];
            endcase
          end
          gs.gate_two = item.gate_level;
        end
      end
    endcase
    ctr_out = s;
    glb_out = gs;
    res.read_data = rd;
    res.irq0_raise = raise;
    res.irq0_drop = drop;
    res.speaker_out = (NUM_COUNTERS > 2) ? out_level(s[2]) : 1'b0;
  end

endmodule
